/* sv/dda_pkg.sv */
// Package for the DDA line rasterizer: fixed widths, shared types and the
// rounding helpers used by the back part.
// Depends on nothing.
package dda_pkg;

    // Coordinate and fixed-point widths.
    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_BITS     = FRAC_BITS + 2;
    localparam int QUO_BITS     = FRAC_BITS + 1;
    localparam int REM_BITS     = COORD_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(QUO_BITS);

    // Command modes on the input channel.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] mag_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;
    typedef logic signed [INC_BITS-1:0]   inc_t;
    typedef logic        [QUO_BITS-1:0]   quo_t;
    typedef logic        [REM_BITS-1:0]   rem_t;

    // Classified command passed from the front part to the back part.
    typedef struct packed {
        logic   adv;
        coord_t start_x;
        coord_t start_y;
        mag_t   mag_x;
        mag_t   mag_y;
        logic   neg_x;
        logic   neg_y;
        mag_t   steps;
    } cmd_t;

    // Back part sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } bk_state_t;

    // Integer coordinate to Q.FRAC_BITS accumulator value.
    function automatic acc_t to_fix(input coord_t c);
        return acc_t'(c) <<< FRAC_BITS;
    endfunction

    // Add one half, then truncate toward zero.
    function automatic coord_t round_fix(input acc_t a);
        acc_t t;
        acc_t q;
        t = a + (acc_t'(1) <<< (FRAC_BITS - 1));
        q = t >>> FRAC_BITS;
        if (t[ACC_BITS-1] && (t[FRAC_BITS-1:0] != '0))
        begin
            q = q + acc_t'(1);
        end
        return q[COORD_BITS-1:0];
    endfunction

endpackage

/* sv/dda_cmd_if.sv */
// Input channel interface of the DDA line rasterizer: handshake and command.
// Depends on dda_pkg for the coordinate type.
interface dda_cmd_if;
    logic               valid;
    logic               ready;
    logic               mode;
    dda_pkg::coord_t    start_x;
    dda_pkg::coord_t    start_y;
    dda_pkg::coord_t    end_x;
    dda_pkg::coord_t    end_y;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

/* sv/dda_pt_if.sv */
// Output channel interface of the DDA line rasterizer: handshake and point.
// Depends on dda_pkg for the coordinate type.
interface dda_pt_if;
    logic               valid;
    logic               ready;
    dda_pkg::coord_t    point_x;
    dda_pkg::coord_t    point_y;
    logic               point_valid;
    logic               point_last;

    modport source (output valid, point_x, point_y, point_valid, point_last, input ready);
    modport sink   (input valid, point_x, point_y, point_valid, point_last, output ready);
endinterface

/* sv/dda_front.sv */
// Front part: accepts input transactions and classifies them into commands
// with endpoint deltas and step count. Depends on dda_pkg and dda_cmd_if.
module dda_front
(
    dda_cmd_if.sink         cmd,
    input  logic            full,
    output logic            push,
    output dda_pkg::cmd_t   cmd_out
);

    logic signed [dda_pkg::COORD_BITS:0] dx;
    logic signed [dda_pkg::COORD_BITS:0] dy;
    logic signed [dda_pkg::COORD_BITS:0] abs_x;
    logic signed [dda_pkg::COORD_BITS:0] abs_y;
    dda_pkg::mag_t                        mag_x;
    dda_pkg::mag_t                        mag_y;

    // Accept whenever the queue has room.
    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;

    // Deltas and their magnitudes; a magnitude always fits the coordinate width.
    always_comb
    begin
        dx    = (dda_pkg::COORD_BITS+1)'(cmd.end_x) - (dda_pkg::COORD_BITS+1)'(cmd.start_x);
        dy    = (dda_pkg::COORD_BITS+1)'(cmd.end_y) - (dda_pkg::COORD_BITS+1)'(cmd.start_y);
        abs_x = dx[dda_pkg::COORD_BITS] ? -dx : dx;
        abs_y = dy[dda_pkg::COORD_BITS] ? -dy : dy;
        mag_x = abs_x[dda_pkg::COORD_BITS-1:0];
        mag_y = abs_y[dda_pkg::COORD_BITS-1:0];
    end

    // Build the command for the back part.
    always_comb
    begin
        cmd_out.adv     = (cmd.mode == dda_pkg::MODE_ADVANCE);
        cmd_out.start_x = cmd.start_x;
        cmd_out.start_y = cmd.start_y;
        cmd_out.mag_x   = mag_x;
        cmd_out.mag_y   = mag_y;
        cmd_out.neg_x   = dx[dda_pkg::COORD_BITS];
        cmd_out.neg_y   = dy[dda_pkg::COORD_BITS];
        cmd_out.steps   = (mag_x > mag_y) ? mag_x : mag_y;
    end

endmodule

/* sv/dda_queue.sv */
// Short command queue between the front and back parts.
// Depends on nothing; width and depth come in as parameters.
module dda_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign full  = (count_reg == CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/dda_back.sv */
// Back part: carries out load and advance commands, runs the restoring
// divider for the increments of both axes and holds the output register.
// Depends on dda_pkg and dda_pt_if.
module dda_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  dda_pkg::cmd_t   cmd_in,
    output logic            pop,
    dda_pt_if.source        pt
);

    dda_pkg::bk_state_t                  state_reg, state_next;
    dda_pkg::acc_t                       acc_x_reg, acc_x_next;
    dda_pkg::acc_t                       acc_y_reg, acc_y_next;
    dda_pkg::inc_t                       inc_x_reg, inc_x_next;
    dda_pkg::inc_t                       inc_y_reg, inc_y_next;
    dda_pkg::mag_t                       steps_left_reg, steps_left_next;
    logic                                active_reg, active_next;
    logic [dda_pkg::DIV_CNT_BITS-1:0]    div_cnt_reg, div_cnt_next;
    dda_pkg::mag_t                       div_steps_reg, div_steps_next;
    dda_pkg::rem_t                       rem_x_reg, rem_x_next;
    dda_pkg::rem_t                       rem_y_reg, rem_y_next;
    dda_pkg::quo_t                       quo_x_reg, quo_x_next;
    dda_pkg::quo_t                       quo_y_reg, quo_y_next;
    logic                                neg_x_reg, neg_x_next;
    logic                                neg_y_reg, neg_y_next;
    logic                                out_valid_reg, out_valid_next;
    dda_pkg::coord_t                     px_reg, px_next;
    dda_pkg::coord_t                     py_reg, py_next;
    logic                                pvalid_reg, pvalid_next;
    logic                                plast_reg, plast_next;

    logic                                can_emit;
    logic                                bit_x;
    logic                                bit_y;
    dda_pkg::rem_t                       rem_x_sub;
    dda_pkg::rem_t                       rem_y_sub;
    dda_pkg::quo_t                       quo_x_new;
    dda_pkg::quo_t                       quo_y_new;
    dda_pkg::acc_t                       adv_x;
    dda_pkg::acc_t                       adv_y;
    dda_pkg::acc_t                       start_fx;
    dda_pkg::acc_t                       start_fy;

    assign pt.valid       = out_valid_reg;
    assign pt.point_x     = px_reg;
    assign pt.point_y     = py_reg;
    assign pt.point_valid = pvalid_reg;
    assign pt.point_last  = plast_reg;

    // A command is taken only when the output register can hold its result.
    assign can_emit = !out_valid_reg || pt.ready;
    assign pop      = (state_reg == dda_pkg::BK_IDLE) && !empty && can_emit;

    // One restoring step per cycle for each axis.
    always_comb
    begin
        bit_x     = (rem_x_reg >= {1'b0, div_steps_reg});
        bit_y     = (rem_y_reg >= {1'b0, div_steps_reg});
        rem_x_sub = bit_x ? rem_x_reg - {1'b0, div_steps_reg} : rem_x_reg;
        rem_y_sub = bit_y ? rem_y_reg - {1'b0, div_steps_reg} : rem_y_reg;
        quo_x_new = {quo_x_reg[dda_pkg::QUO_BITS-2:0], bit_x};
        quo_y_new = {quo_y_reg[dda_pkg::QUO_BITS-2:0], bit_y};
    end

    // Accumulator step and start position.
    always_comb
    begin
        adv_x    = acc_x_reg + dda_pkg::acc_t'(inc_x_reg);
        adv_y    = acc_y_reg + dda_pkg::acc_t'(inc_y_reg);
        start_fx = dda_pkg::to_fix(cmd_in.start_x);
        start_fy = dda_pkg::to_fix(cmd_in.start_y);
    end

    // Sequencer: command execution, divider iterations and output register.
    always_comb
    begin
        state_next      = state_reg;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        steps_left_next = steps_left_reg;
        active_next     = active_reg;
        div_cnt_next    = div_cnt_reg;
        div_steps_next  = div_steps_reg;
        rem_x_next      = rem_x_reg;
        rem_y_next      = rem_y_reg;
        quo_x_next      = quo_x_reg;
        quo_y_next      = quo_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pvalid_next     = pvalid_reg;
        plast_next      = plast_reg;
        out_valid_next  = pt.ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            dda_pkg::BK_IDLE:
            begin
                if (pop)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_in.adv)
                    begin
                        if (active_reg)
                        begin
                            acc_x_next      = adv_x;
                            acc_y_next      = adv_y;
                            steps_left_next = steps_left_reg - 1'b1;
                            px_next         = dda_pkg::round_fix(adv_x);
                            py_next         = dda_pkg::round_fix(adv_y);
                            pvalid_next     = 1'b1;
                            plast_next      = (steps_left_reg == dda_pkg::mag_t'(1));
                            active_next     = (steps_left_reg != dda_pkg::mag_t'(1));
                        end
                        else
                        begin
                            px_next     = '0;
                            py_next     = '0;
                            pvalid_next = 1'b0;
                            plast_next  = 1'b0;
                        end
                    end
                    else if (cmd_in.steps == '0)
                    begin
                        // Equal endpoints: a single point, no division.
                        acc_x_next      = start_fx;
                        acc_y_next      = start_fy;
                        inc_x_next      = '0;
                        inc_y_next      = '0;
                        steps_left_next = '0;
                        active_next     = 1'b0;
                        px_next         = cmd_in.start_x;
                        py_next         = cmd_in.start_y;
                        pvalid_next     = 1'b1;
                        plast_next      = 1'b1;
                    end
                    else
                    begin
                        // Emit the rounded start point and start the divider.
                        acc_x_next      = start_fx;
                        acc_y_next      = start_fy;
                        steps_left_next = cmd_in.steps;
                        active_next     = 1'b1;
                        px_next         = dda_pkg::round_fix(start_fx);
                        py_next         = dda_pkg::round_fix(start_fy);
                        pvalid_next     = 1'b1;
                        plast_next      = 1'b0;
                        div_cnt_next    = '0;
                        div_steps_next  = cmd_in.steps;
                        rem_x_next      = {1'b0, cmd_in.mag_x};
                        rem_y_next      = {1'b0, cmd_in.mag_y};
                        quo_x_next      = '0;
                        quo_y_next      = '0;
                        neg_x_next      = cmd_in.neg_x;
                        neg_y_next      = cmd_in.neg_y;
                        state_next      = dda_pkg::BK_DIV;
                    end
                end
            end

            dda_pkg::BK_DIV:
            begin
                rem_x_next   = {rem_x_sub[dda_pkg::REM_BITS-2:0], 1'b0};
                rem_y_next   = {rem_y_sub[dda_pkg::REM_BITS-2:0], 1'b0};
                quo_x_next   = quo_x_new;
                quo_y_next   = quo_y_new;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == dda_pkg::DIV_CNT_BITS'(dda_pkg::QUO_BITS - 1))
                begin
                    // Last quotient bit: apply the sign and load the increments.
                    inc_x_next = neg_x_reg ? -dda_pkg::inc_t'({1'b0, quo_x_new})
                                           :  dda_pkg::inc_t'({1'b0, quo_x_new});
                    inc_y_next = neg_y_reg ? -dda_pkg::inc_t'({1'b0, quo_y_new})
                                           :  dda_pkg::inc_t'({1'b0, quo_y_new});
                    state_next = dda_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = dda_pkg::BK_IDLE;
            end
        endcase
    end

    // Control and line state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dda_pkg::BK_IDLE;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_x_reg      <= acc_x_next;
            acc_y_reg      <= acc_y_next;
            inc_x_reg      <= inc_x_next;
            inc_y_reg      <= inc_y_next;
            steps_left_reg <= steps_left_next;
            active_reg     <= active_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Divider operands and output payload.
    always_ff @(posedge clk)
    begin
        div_steps_reg <= div_steps_next;
        rem_x_reg     <= rem_x_next;
        rem_y_reg     <= rem_y_next;
        quo_x_reg     <= quo_x_next;
        quo_y_reg     <= quo_y_next;
        neg_x_reg     <= neg_x_next;
        neg_y_reg     <= neg_y_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        pvalid_reg    <= pvalid_next;
        plast_reg     <= plast_next;
    end

endmodule

/* sv/dda_line_rasterizer.sv */
// Top level of the DDA line rasterizer: front classifier, command queue and
// back executor. Depends on dda_pkg, dda_cmd_if, dda_pt_if and the submodules.
//
//   Channel | Direction | Transaction
//   --------+-----------+------------------------------------------------
//   cmd     | in        | mode, start_x, start_y, end_x, end_y
//   pt      | out       | point_x, point_y, point_valid, point_last
//
// Every cmd transaction yields exactly one pt transaction, in order.
// An advance needs no division in the back part, so points stream at one per
// cycle while commands are queued and the output is ready. A load with distinct
// endpoints holds the back part, one quotient bit per cycle in the restoring
// divider. The queue keeps accepting up to QUEUE_DEPTH commands while the back
// part divides or the output stalls. Reset clears the queue and all line state.
module dda_line_rasterizer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    dda_cmd_if.sink   cmd,
    dda_pt_if.source  pt
);

    localparam int CMD_BITS = $bits(dda_pkg::cmd_t);

    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    dda_pkg::cmd_t       front_cmd;
    logic [CMD_BITS-1:0] queue_rdata;
    dda_pkg::cmd_t       back_cmd;

    // Classify incoming transactions.
    dda_front u_front
    (
        .cmd     (cmd),
        .full    (full),
        .push    (push),
        .cmd_out (front_cmd)
    );

    // Decouple the front from the back.
    dda_queue
    #(
        .WIDTH (CMD_BITS),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (pop),
        .rdata (queue_rdata),
        .empty (empty)
    );

    assign back_cmd = dda_pkg::cmd_t'(queue_rdata);

    // Execute commands and drive the point channel.
    dda_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .cmd_in (back_cmd),
        .pop    (pop),
        .pt     (pt)
    );

endmodule
